/* hdl/gjmi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_pkg
// Shared constants and types for the Gauss-Jordan matrix inverter.
// ----------------------------------------------------------------------------
package gjmi_pkg;

  // Fixed-point format: signed Q.16 fraction.
  localparam int FRAC_BITS = 16;

  // Status codes carried with every result word.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REUSED = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  // Write enables of the two matrix stores.
  typedef struct packed {
    logic a;
    logic b;
  } mem_we_t;

endpackage

/* hdl/gjmi_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_ifs
// Valid/ready channels of the matrix inverter: input words, result words and
// the matrix size register write.
// ----------------------------------------------------------------------------
interface gjmi_item_if #(parameter int DW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] a_element;
  logic signed [DW-1:0] b_element;
  modport source (output valid, a_element, b_element, input ready);
  modport sink   (input valid, a_element, b_element, output ready);
endinterface

interface gjmi_result_if #(parameter int DW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] inverse_element;
  logic signed [DW-1:0] companion_element;
  logic [1:0]           status;
  logic                 last_element;
  modport source (output valid, inverse_element, companion_element, status, last_element,
                  input ready);
  modport sink   (input valid, inverse_element, companion_element, status, last_element,
                  output ready);
endinterface

interface gjmi_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] matrix_size;
  modport source (output valid, matrix_size, input ready);
  modport sink   (input valid, matrix_size, output ready);
endinterface

/* hdl/gjmi_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_mem
// Paired matrix stores with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gjmi_mem
  import gjmi_pkg::*;
#(
  parameter int DW    = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0] rd_a,
  output logic signed [DW-1:0] rd_b,
  input  logic [AW-1:0]        wr_addr,
  input  mem_we_t              we,
  input  logic signed [DW-1:0] wd_a,
  input  logic signed [DW-1:0] wd_b
);

  logic signed [DW-1:0] a_mem [DEPTH];
  logic signed [DW-1:0] b_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.a) begin
      a_mem[wr_addr] <= wd_a;
    end
    if (we.b) begin
      b_mem[wr_addr] <= wd_b;
    end
    rd_a <= a_mem[rd_addr];
    rd_b <= b_mem[rd_addr];
  end

endmodule

/* hdl/gjmi_recip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_recip
// Bit-serial restoring divider forming the saturated fixed-point reciprocal.
// ----------------------------------------------------------------------------
module gjmi_recip
  import gjmi_pkg::*;
#(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int QW   = 2 * FRAC_BITS + 1;
  localparam int CNTW = $clog2(QW + 1);
  localparam int RW   = DW + 1;
  localparam int SW   = QW + DW;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dv;
  logic [QW-1:0]   q;
  logic            neg;

  logic          num_bit;
  logic [RW-1:0] shifted;
  logic          fits;
  logic [SW-1:0] q_ext;
  logic [SW-1:0] max_pos;
  logic [SW-1:0] max_neg;

  // The numerator is a lone one in its top bit.
  assign num_bit = (cnt == CNTW'(QW));
  assign shifted = {rem, num_bit};
  assign fits    = (shifted >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW);
        rem  <= '0;
        q    <= '0;
        neg  <= divisor[DW-1];
        dv   <= divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
      end else if (busy) begin
        rem <= fits ? DW'(shifted - {1'b0, dv}) : DW'(shifted);
        q   <= {q[QW-2:0], fits};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign q_ext   = SW'(q);
  assign max_pos = SW'({(DW-1){1'b1}});
  assign max_neg = SW'(1) << (DW - 1);

  always_comb begin
    if (neg) begin
      quotient = (q_ext > max_neg) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q_ext);
    end else begin
      quotient = (q_ext > max_pos) ? {1'b0, {(DW-1){1'b1}}} : DW'(q_ext);
    end
  end

endmodule

/* hdl/gjmi_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjmi_mac
// Two-stage fixed-point multiply added to or subtracted from a scaled base,
// with rounding half away from zero and saturation.
// ----------------------------------------------------------------------------
module gjmi_mac
  import gjmi_pkg::*;
#(
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] base,
  input  logic signed [DW-1:0] y,
  input  logic signed [DW-1:0] z,
  input  logic                 sub,
  output logic signed [DW-1:0] res
);

  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 2;

  logic signed [PW-1:0] prod_q;
  logic signed [DW-1:0] base_q;
  logic                 sub_q;

  logic signed [SW-1:0] base_ext;
  logic signed [SW-1:0] prod_ext;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        mag;
  logic [SW-1:0]        rnd;
  logic                 neg;
  logic signed [DW-1:0] res_next;

  always_ff @(posedge clk) begin
    prod_q <= y * z;
    base_q <= base;
    sub_q  <= sub;
    res    <= res_next;
  end

  always_comb begin
    base_ext = SW'(base_q) <<< FRAC_BITS;
    prod_ext = SW'(prod_q);
    sum      = sub_q ? (base_ext - prod_ext) : (base_ext + prod_ext);
    neg      = sum[SW-1];
    mag      = neg ? SW'(-sum) : SW'(sum);
    rnd      = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) begin
      res_next = (rnd > (SW'(1) << (DW - 1))) ? {1'b1, {(DW-1){1'b0}}} : DW'(-rnd);
    end else begin
      res_next = (rnd > SW'({(DW-1){1'b1}})) ? {1'b0, {(DW-1){1'b1}}} : DW'(rnd);
    end
  end

endmodule

/* hdl/gauss_jordan_matrix_inverse_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverse_top
// Gauss-Jordan inverter with full pivoting over a matrix pair held in memory.
// ----------------------------------------------------------------------------
// The block takes one word per cycle (an element of A and the element of B at
// the same place, row-major) until n*n words of the configured size n are in
// the stores. It then inverts A in place with full pivoting, applies the same
// row operations to B, undoes the column interchanges on A and returns n*n
// result words, row-major, each with the status and a last mark on the final
// word. No input word is taken from the start of the inversion until the last
// result word has been taken. All elimination work goes through one read port
// and one write port of the stores, so the inversion time is set by memory
// accesses: each pivot step holds the pivot search over the unused candidates,
// a row interchange when the pivot lies off the diagonal, the bit-serial
// reciprocal of the pivot, the scaling of the pivot row and the elimination of
// the other rows; then the column interchanges are undone on A, and the
// readout of each result word waits for the sink to be ready. A write to
// matrix_size restarts the load; a size of 0 acts as 1 and a size above
// MAX_SIZE acts as MAX_SIZE. A singular matrix stops the elimination and
// returns the stores as they stand.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverse_top
  import gjmi_pkg::*;
#(
  parameter int MAX_SIZE   = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  gjmi_cfg_if.sink       cfg,
  gjmi_item_if.sink      items,
  gjmi_result_if.source  results
);

  localparam int DW    = DATA_WIDTH;
  localparam int IW    = $clog2(MAX_SIZE);
  localparam int CW    = IW + 1;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic signed [DW-1:0] ONE = DW'(1 << FRAC_BITS);

  // Controller states.
  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_CHK      = 5'd2;
  localparam logic [4:0] S_SCAN     = 5'd3;
  localparam logic [4:0] S_SCAN_EV  = 5'd4;
  localparam logic [4:0] S_PIV      = 5'd5;
  localparam logic [4:0] S_SW1      = 5'd6;
  localparam logic [4:0] S_SW2      = 5'd7;
  localparam logic [4:0] S_SW3      = 5'd8;
  localparam logic [4:0] S_SW4      = 5'd9;
  localparam logic [4:0] S_DRD      = 5'd10;
  localparam logic [4:0] S_DEV      = 5'd11;
  localparam logic [4:0] S_DIV      = 5'd12;
  localparam logic [4:0] S_SC_RD    = 5'd13;
  localparam logic [4:0] S_SC_MUL   = 5'd14;
  localparam logic [4:0] S_SC_M2    = 5'd15;
  localparam logic [4:0] S_SC_WR    = 5'd16;
  localparam logic [4:0] S_EL_J     = 5'd17;
  localparam logic [4:0] S_EL_D     = 5'd18;
  localparam logic [4:0] S_EL_P     = 5'd19;
  localparam logic [4:0] S_EL_X     = 5'd20;
  localparam logic [4:0] S_EL_MUL   = 5'd21;
  localparam logic [4:0] S_EL_M2    = 5'd22;
  localparam logic [4:0] S_EL_WR    = 5'd23;
  localparam logic [4:0] S_UNS_INIT = 5'd24;
  localparam logic [4:0] S_UNS_NEXT = 5'd25;
  localparam logic [4:0] S_OUT_INIT = 5'd26;
  localparam logic [4:0] S_OUT_RD   = 5'd27;
  localparam logic [4:0] S_OUT_LD   = 5'd28;
  localparam logic [4:0] S_OUT_WAIT = 5'd29;

  function automatic logic [AW-1:0] at(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_SIZE + int'(c));
  endfunction

  logic [4:0] state;
  logic [2:0] msize;
  logic [CW-1:0] n;

  // Load position.
  logic [CW-1:0] lr;
  logic [CW-1:0] lc;

  // Elimination bookkeeping.
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [CW-1:0] l;
  logic [CW-1:0] u;
  logic [DW-1:0] big;
  logic [IW-1:0] prow;
  logic [IW-1:0] pcol;
  logic [IW-1:0] ur;
  logic [IW-1:0] uc;
  logic          sw_col;
  logic [1:0]    use_cnt [MAX_SIZE];
  logic [IW-1:0] row_log [MAX_SIZE];
  logic [IW-1:0] col_log [MAX_SIZE];
  logic [1:0]    st;

  logic signed [DW-1:0] t1_a;
  logic signed [DW-1:0] t1_b;
  logic signed [DW-1:0] p_a;
  logic signed [DW-1:0] p_b;
  logic signed [DW-1:0] d;
  logic signed [DW-1:0] pinv;

  // Readout position and output register.
  logic [CW-1:0]        orow;
  logic [CW-1:0]        ocol;
  logic                 ovalid;
  logic signed [DW-1:0] o_a;
  logic signed [DW-1:0] o_b;
  logic                 olast;

  // Memory and arithmetic ports.
  logic [AW-1:0]        rd_addr;
  logic signed [DW-1:0] rd_a;
  logic signed [DW-1:0] rd_b;
  logic [AW-1:0]        wr_addr;
  mem_we_t              we;
  logic signed [DW-1:0] wd_a;
  logic signed [DW-1:0] wd_b;
  logic signed [DW-1:0] mac_base_a;
  logic signed [DW-1:0] mac_base_b;
  logic signed [DW-1:0] mac_y_a;
  logic signed [DW-1:0] mac_y_b;
  logic signed [DW-1:0] mac_z;
  logic                 mac_sub;
  logic signed [DW-1:0] res_a;
  logic signed [DW-1:0] res_b;
  logic                 div_start;
  logic                 div_done;
  logic signed [DW-1:0] div_q;

  logic          item_fire;
  logic          reuse;
  logic [DW-1:0] rd_mag;
  logic [AW-1:0] sw_addr1;
  logic [AW-1:0] sw_addr2;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] u_m1;

  // Effective size after clamping the register to 1..MAX_SIZE.
  always_comb begin
    if (msize == 3'd0) begin
      n = CW'(1);
    end else if (int'(msize) > MAX_SIZE) begin
      n = CW'(MAX_SIZE);
    end else begin
      n = CW'(msize);
    end
  end

  assign n_m1 = n - CW'(1);
  assign u_m1 = u - CW'(1);

  // The pivot search gives up when some row is still open and some column has
  // already served as pivot more than once.
  always_comb begin
    logic open_row;
    logic twice;
    open_row = 1'b0;
    twice    = 1'b0;
    for (int m = 0; m < MAX_SIZE; m++) begin
      if (m < int'(n)) begin
        if (use_cnt[m] != 2'd1) open_row = 1'b1;
        if (use_cnt[m] > 2'd1)  twice    = 1'b1;
      end
    end
    reuse = open_row && twice;
  end

  assign rd_mag    = rd_a[DW-1] ? DW'(-rd_a) : DW'(rd_a);
  assign item_fire = items.valid && items.ready;
  assign sw_addr1  = sw_col ? at(l[IW-1:0], ur) : at(prow, l[IW-1:0]);
  assign sw_addr2  = sw_col ? at(l[IW-1:0], uc) : at(pcol, l[IW-1:0]);

  assign items.ready = (state == S_LOAD);
  assign cfg.ready   = 1'b1;

  assign results.valid             = ovalid;
  assign results.inverse_element   = o_a;
  assign results.companion_element = o_b;
  assign results.status            = st;
  assign results.last_element      = olast;

  // Memory port selection per state.
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    we      = '0;
    wd_a    = '0;
    wd_b    = '0;
    case (state)
      S_LOAD: begin
        wr_addr = at(lr[IW-1:0], lc[IW-1:0]);
        we.a    = item_fire;
        we.b    = item_fire;
        wd_a    = items.a_element;
        wd_b    = items.b_element;
      end
      S_SCAN:   rd_addr = at(j[IW-1:0], k[IW-1:0]);
      S_SW1:    rd_addr = sw_addr1;
      S_SW2:    rd_addr = sw_addr2;
      S_SW3: begin
        wr_addr = sw_addr1;
        we.a    = 1'b1;
        we.b    = !sw_col;
        wd_a    = rd_a;
        wd_b    = rd_b;
      end
      S_SW4: begin
        wr_addr = sw_addr2;
        we.a    = 1'b1;
        we.b    = !sw_col;
        wd_a    = t1_a;
        wd_b    = t1_b;
      end
      S_DRD:    rd_addr = at(pcol, pcol);
      S_SC_RD:  rd_addr = at(pcol, l[IW-1:0]);
      S_SC_WR: begin
        wr_addr = at(pcol, l[IW-1:0]);
        we      = '{a: 1'b1, b: 1'b1};
        wd_a    = res_a;
        wd_b    = res_b;
      end
      S_EL_J:   rd_addr = at(j[IW-1:0], pcol);
      S_EL_P:   rd_addr = at(pcol, l[IW-1:0]);
      S_EL_X:   rd_addr = at(j[IW-1:0], l[IW-1:0]);
      S_EL_WR: begin
        wr_addr = at(j[IW-1:0], l[IW-1:0]);
        we      = '{a: 1'b1, b: 1'b1};
        wd_a    = res_a;
        wd_b    = res_b;
      end
      S_OUT_RD: rd_addr = at(orow[IW-1:0], ocol[IW-1:0]);
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Operands of the two arithmetic lanes. The pivot element is taken as one
  // while scaling, and the eliminated column of A starts from zero.
  always_comb begin
    mac_base_a = '0;
    mac_base_b = '0;
    mac_y_a    = '0;
    mac_y_b    = '0;
    mac_z      = '0;
    mac_sub    = 1'b0;
    if (state == S_SC_MUL) begin
      mac_y_a = (l[IW-1:0] == pcol) ? ONE : rd_a;
      mac_y_b = rd_b;
      mac_z   = pinv;
    end else if (state == S_EL_MUL) begin
      mac_base_a = (l[IW-1:0] == pcol) ? '0 : rd_a;
      mac_base_b = rd_b;
      mac_y_a    = p_a;
      mac_y_b    = p_b;
      mac_z      = d;
      mac_sub    = 1'b1;
    end
  end

  assign div_start = (state == S_DEV) && (rd_a != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      msize  <= 3'd4;
      lr     <= '0;
      lc     <= '0;
      ovalid <= 1'b0;
      st     <= ST_OK;
      for (int m = 0; m < MAX_SIZE; m++) begin
        use_cnt[m] <= 2'd0;
      end
    end else begin
      case (state)
        S_LOAD: begin
          if (item_fire) begin
            if (lc == n_m1) begin
              lc <= '0;
              if (lr == n_m1) begin
                lr    <= '0;
                state <= S_START;
              end else begin
                lr <= lr + CW'(1);
              end
            end else begin
              lc <= lc + CW'(1);
            end
          end
        end
        S_START: begin
          for (int m = 0; m < MAX_SIZE; m++) begin
            use_cnt[m] <= 2'd0;
          end
          i     <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (i == n) begin
            state <= S_UNS_INIT;
          end else if (reuse) begin
            st    <= ST_REUSED;
            state <= S_OUT_INIT;
          end else begin
            j     <= '0;
            k     <= '0;
            big   <= '0;
            prow  <= '0;
            pcol  <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (j == n) begin
            state <= S_PIV;
          end else if (use_cnt[j[IW-1:0]] == 2'd1 || k == n) begin
            j <= j + CW'(1);
            k <= '0;
          end else if (use_cnt[k[IW-1:0]] != 2'd0) begin
            k <= k + CW'(1);
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          // Ties go to the later candidate in scan order.
          if (rd_mag >= big) begin
            big  <= rd_mag;
            prow <= j[IW-1:0];
            pcol <= k[IW-1:0];
          end
          k     <= k + CW'(1);
          state <= S_SCAN;
        end
        S_PIV: begin
          if (use_cnt[pcol] != 2'd3) begin
            use_cnt[pcol] <= use_cnt[pcol] + 2'd1;
          end
          row_log[i[IW-1:0]] <= prow;
          col_log[i[IW-1:0]] <= pcol;
          l      <= '0;
          sw_col <= 1'b0;
          state  <= (prow != pcol) ? S_SW1 : S_DRD;
        end
        S_SW1: begin
          if (l == n) begin
            state <= sw_col ? S_UNS_NEXT : S_DRD;
          end else begin
            state <= S_SW2;
          end
        end
        S_SW2: begin
          t1_a  <= rd_a;
          t1_b  <= rd_b;
          state <= S_SW3;
        end
        S_SW3: state <= S_SW4;
        S_SW4: begin
          l     <= l + CW'(1);
          state <= S_SW1;
        end
        S_DRD: state <= S_DEV;
        S_DEV: begin
          if (rd_a == '0) begin
            st    <= ST_ZERO;
            state <= S_OUT_INIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pinv  <= div_q;
            l     <= '0;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          if (l == n) begin
            j     <= '0;
            state <= S_EL_J;
          end else begin
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: state <= S_SC_M2;
        S_SC_M2:  state <= S_SC_WR;
        S_SC_WR: begin
          l     <= l + CW'(1);
          state <= S_SC_RD;
        end
        S_EL_J: begin
          if (j == n) begin
            i     <= i + CW'(1);
            state <= S_CHK;
          end else if (j == {1'b0, pcol}) begin
            j <= j + CW'(1);
          end else begin
            state <= S_EL_D;
          end
        end
        S_EL_D: begin
          d     <= rd_a;
          l     <= '0;
          state <= S_EL_P;
        end
        S_EL_P: begin
          if (l == n) begin
            j     <= j + CW'(1);
            state <= S_EL_J;
          end else begin
            state <= S_EL_X;
          end
        end
        S_EL_X: begin
          p_a   <= rd_a;
          p_b   <= rd_b;
          state <= S_EL_MUL;
        end
        S_EL_MUL: state <= S_EL_M2;
        S_EL_M2:  state <= S_EL_WR;
        S_EL_WR: begin
          l     <= l + CW'(1);
          state <= S_EL_P;
        end
        S_UNS_INIT: begin
          u     <= n;
          state <= S_UNS_NEXT;
        end
        S_UNS_NEXT: begin
          // Column interchanges are undone from the last pivot step back.
          if (u == '0) begin
            st    <= ST_OK;
            state <= S_OUT_INIT;
          end else begin
            u  <= u_m1;
            ur <= row_log[u_m1[IW-1:0]];
            uc <= col_log[u_m1[IW-1:0]];
            if (row_log[u_m1[IW-1:0]] != col_log[u_m1[IW-1:0]]) begin
              l      <= '0;
              sw_col <= 1'b1;
              state  <= S_SW1;
            end
          end
        end
        S_OUT_INIT: begin
          orow  <= '0;
          ocol  <= '0;
          state <= S_OUT_RD;
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          o_a    <= rd_a;
          o_b    <= rd_b;
          olast  <= (orow == n_m1) && (ocol == n_m1);
          ovalid <= 1'b1;
          if (ocol == n_m1) begin
            ocol <= '0;
            orow <= orow + CW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
          state <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (results.ready) begin
            ovalid <= 1'b0;
            state  <= olast ? S_LOAD : S_OUT_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase

      // A size write discards any partial load.
      if (cfg.valid) begin
        msize <= cfg.matrix_size;
        lr    <= '0;
        lc    <= '0;
      end
    end
  end

  gjmi_mem #(
    .DW    (DW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .wr_addr (wr_addr),
    .we      (we),
    .wd_a    (wd_a),
    .wd_b    (wd_b)
  );

  gjmi_recip #(
    .DW (DW)
  ) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (rd_a),
    .done     (div_done),
    .quotient (div_q)
  );

  gjmi_mac #(
    .DW (DW)
  ) u_mac_a (
    .clk  (clk),
    .base (mac_base_a),
    .y    (mac_y_a),
    .z    (mac_z),
    .sub  (mac_sub),
    .res  (res_a)
  );

  gjmi_mac #(
    .DW (DW)
  ) u_mac_b (
    .clk  (clk),
    .base (mac_base_b),
    .y    (mac_y_b),
    .z    (mac_z),
    .sub  (mac_sub),
    .res  (res_b)
  );

endmodule
